/* rtl/assert_macros.svh */
// Assertion macros for the block checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, also checked during reset.
`define ASSERT_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/spmw_pkg.sv */
`default_nettype none
package spmw_pkg;

  localparam int DATA_W            = 32;
  localparam int LEN_W             = 6;
  localparam int ACT_W             = 2;
  localparam int GUARD_W           = 2;
  localparam int MAX_WORD_BITS_DEF = 32;
  localparam int ADDR_W            = 5;
  localparam int PDATA_W           = 32;
  localparam int REG_IDX_W         = 3;

  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_CPOL      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CPHA      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LSB_FIRST = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CS_LEVEL  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GUARD     = 3'd4;

  localparam logic [GUARD_W-1:0] GUARD_RESET = 2'd1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_GUARD = 2'd1,
    PH_SHIFT = 2'd2,
    PH_OPEN  = 2'd3
  } phase_t;

  typedef struct packed {
    logic               cpol;
    logic               cpha;
    logic               lsb_first;
    logic               cs_active;
    logic [GUARD_W-1:0] guard;
  } cfg_t;

endpackage
`default_nettype wire

/* rtl/spmw_if.sv */
`default_nettype none
interface spmw_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [spmw_pkg::ACT_W-1:0]       action;
  logic [spmw_pkg::LEN_W-1:0]       word_bits;
  logic [spmw_pkg::DATA_W-1:0]      tx_word;
  logic                             last_in_frame;
  logic                             din_sample;

  modport source (output valid, action, word_bits, tx_word, last_in_frame, din_sample,
                  input ready);
  modport sink (input valid, action, word_bits, tx_word, last_in_frame, din_sample,
                output ready);
endinterface

interface spmw_res_if;
  logic                        valid;
  logic                        ready;
  logic                        cs_level;
  logic                        sclk_level;
  logic                        dout_level;
  logic                        ready_res;
  logic                        rx_valid;
  logic [spmw_pkg::DATA_W-1:0] rx_word;
  logic                        rejected;

  modport source (output valid, cs_level, sclk_level, dout_level, ready_res, rx_valid,
                  rx_word, rejected, input ready);
  modport sink (input valid, cs_level, sclk_level, dout_level, ready_res, rx_valid,
                rx_word, rejected, output ready);
endinterface
`default_nettype wire

/* rtl/spi_master_variable_word_core.sv */
// Tick-driven SPI master, one input transfer per serial tick.
// An accepted tick passes through the input register and then the result register.
// Throughput: one tick per cycle while the result side takes every result.
// Reset (rst, synchronous, active high): frame idle, all counters and shift registers
// cleared, config back to defaults (mode 0, MSB first, CS active low, one guard tick).
`default_nettype none
module spi_master_variable_word_core #(
  parameter int MAX_WORD_BITS = spmw_pkg::MAX_WORD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  spmw_cmd_if.sink                           cmd,
  spmw_res_if.source                         res,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [spmw_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [spmw_pkg::PDATA_W-1:0]  pwdata,
  output logic      [spmw_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);

  localparam int DW    = spmw_pkg::DATA_W;
  localparam int LW    = spmw_pkg::LEN_W;
  localparam int GW    = spmw_pkg::GUARD_W;
  localparam int IDX_W = $clog2(DW);

  spmw_pkg::cfg_t cfg;

  spmw_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register
  logic                        in_v;
  logic [spmw_pkg::ACT_W-1:0]  in_act;
  logic [LW-1:0]               in_bits;
  logic [DW-1:0]               in_tx;
  logic                        in_last;
  logic                        in_din;
  logic                        advance;

  assign advance   = in_v && (!res.valid || res.ready);
  assign cmd.ready = !rst && (!in_v || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      in_v <= 1'b1;
    end else if (advance) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_act  <= cmd.action;
      in_bits <= cmd.word_bits;
      in_tx   <= cmd.tx_word;
      in_last <= cmd.last_in_frame;
      in_din  <= cmd.din_sample;
    end
  end

  // Frame state
  spmw_pkg::phase_t phase, phase_next;
  logic [GW-1:0]    guard_count, guard_count_next;
  logic [1:0]       tick_in_bit, tick_in_bit_next;
  logic [LW-1:0]    bit_index, bit_index_next;
  logic [LW-1:0]    word_length, word_length_next;
  logic [DW-1:0]    tx_shift, tx_shift_next;
  logic [DW-1:0]    rx_accum, rx_accum_next;
  logic             is_read, is_read_next;
  logic             end_after_word, end_after_word_next;
  logic             sclk_reg, sclk_next;
  logic             dout_reg, dout_next;

  // Decoded per-tick terms
  logic             is_cmd;
  logic             start;
  logic [LW-1:0]    bits_eff;
  logic [GW-1:0]    guard_val;
  logic [LW-1:0]    bit_index_inc;
  logic [LW-1:0]    pos;
  logic             pos_in_range;
  logic             bitv;
  logic             shift_done;
  logic             word_end;
  logic             sample;
  logic             rxv;
  logic             rej;

  assign is_cmd = (in_act == spmw_pkg::ACT_WRITE) || (in_act == spmw_pkg::ACT_READ);
  assign start  = ((phase == spmw_pkg::PH_IDLE) || (phase == spmw_pkg::PH_OPEN)) && is_cmd;
  assign rej    = is_cmd && ((phase == spmw_pkg::PH_GUARD) || (phase == spmw_pkg::PH_SHIFT));

  always_comb begin
    if (in_bits == '0) begin
      bits_eff = LW'(1);
    end else if (int'(in_bits) > MAX_WORD_BITS) begin
      bits_eff = LW'(MAX_WORD_BITS);
    end else begin
      bits_eff = in_bits;
    end
  end

  always_comb begin
    case (cfg.guard)
      2'd0:    guard_val = 2'd1;
      2'd3:    guard_val = 2'd2;
      default: guard_val = cfg.guard;
    endcase
  end

  assign bit_index_inc = bit_index + LW'(1);
  assign pos           = cfg.lsb_first ? bit_index : (word_length - LW'(1) - bit_index);
  assign pos_in_range  = (pos < LW'(DW));
  assign bitv          = pos_in_range && tx_shift[pos[IDX_W-1:0]];
  assign shift_done    = (phase == spmw_pkg::PH_SHIFT) && (tick_in_bit == 2'd3);
  assign word_end      = shift_done && (bit_index_inc >= word_length);
  assign sample        = (phase == spmw_pkg::PH_SHIFT) &&
                         (cfg.cpha ? (tick_in_bit == 2'd3) : (tick_in_bit == 2'd0));
  assign rxv           = word_end && is_read;

  // Next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      spmw_pkg::PH_IDLE: begin
        if (is_cmd) phase_next = spmw_pkg::PH_GUARD;
      end
      spmw_pkg::PH_OPEN: begin
        if (is_cmd) phase_next = spmw_pkg::PH_SHIFT;
      end
      spmw_pkg::PH_GUARD: begin
        if (guard_count == '0) begin
          phase_next = (bit_index < word_length) ? spmw_pkg::PH_SHIFT : spmw_pkg::PH_IDLE;
        end
      end
      spmw_pkg::PH_SHIFT: begin
        if (word_end) begin
          phase_next = end_after_word ? spmw_pkg::PH_GUARD : spmw_pkg::PH_OPEN;
        end
      end
      default: phase_next = spmw_pkg::PH_IDLE;
    endcase
  end

  // Datapath and pin updates
  always_comb begin
    guard_count_next    = guard_count;
    tick_in_bit_next    = tick_in_bit;
    bit_index_next      = bit_index;
    word_length_next    = word_length;
    tx_shift_next       = tx_shift;
    rx_accum_next       = rx_accum;
    is_read_next        = is_read;
    end_after_word_next = end_after_word;
    sclk_next           = sclk_reg;
    dout_next           = dout_reg;

    if (start) begin
      word_length_next    = bits_eff;
      bit_index_next      = '0;
      tick_in_bit_next    = '0;
      tx_shift_next       = in_tx;
      rx_accum_next       = '0;
      is_read_next        = (in_act == spmw_pkg::ACT_READ);
      end_after_word_next = in_last;
      if (phase == spmw_pkg::PH_IDLE) guard_count_next = guard_val - GW'(1);
    end else if (phase == spmw_pkg::PH_GUARD) begin
      if (guard_count != '0) guard_count_next = guard_count - GW'(1);
    end else if (phase == spmw_pkg::PH_SHIFT) begin
      if (!cfg.cpha) begin
        case (tick_in_bit)
          2'd0:    if (!is_read) dout_next = bitv;
          2'd1:    sclk_next = !cfg.cpol;
          2'd2:    ;
          default: sclk_next = cfg.cpol;
        endcase
      end else begin
        case (tick_in_bit)
          2'd0: begin
            sclk_next = !cfg.cpol;
            if (!is_read) dout_next = bitv;
          end
          2'd1:    ;
          2'd2:    sclk_next = cfg.cpol;
          default: ;
        endcase
      end
      if (sample && is_read && pos_in_range) begin
        rx_accum_next = rx_accum | (DW'(in_din) << pos[IDX_W-1:0]);
      end
      tick_in_bit_next = tick_in_bit + 2'd1;
      if (shift_done) bit_index_next = bit_index_inc;
      if (word_end && end_after_word) guard_count_next = guard_val;
    end

    // Outside shifting, sclk rests at the idle level
    if (phase_next != spmw_pkg::PH_SHIFT) sclk_next = cfg.cpol;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= spmw_pkg::PH_IDLE;
      guard_count    <= '0;
      tick_in_bit    <= '0;
      bit_index      <= '0;
      word_length    <= '0;
      tx_shift       <= '0;
      rx_accum       <= '0;
      is_read        <= 1'b0;
      end_after_word <= 1'b0;
      sclk_reg       <= 1'b0;
      dout_reg       <= 1'b0;
    end else if (advance) begin
      phase          <= phase_next;
      guard_count    <= guard_count_next;
      tick_in_bit    <= tick_in_bit_next;
      bit_index      <= bit_index_next;
      word_length    <= word_length_next;
      tx_shift       <= tx_shift_next;
      rx_accum       <= rx_accum_next;
      is_read        <= is_read_next;
      end_after_word <= end_after_word_next;
      sclk_reg       <= sclk_next;
      dout_reg       <= dout_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.cs_level   <= (phase_next != spmw_pkg::PH_IDLE) ? cfg.cs_active : !cfg.cs_active;
      res.sclk_level <= sclk_next;
      res.dout_level <= dout_next;
      res.ready_res  <= (phase_next == spmw_pkg::PH_IDLE) ||
                        (phase_next == spmw_pkg::PH_OPEN);
      res.rx_valid   <= rxv;
      res.rx_word    <= rxv ? rx_accum_next : '0;
      res.rejected   <= rej;
    end
  end

endmodule
`default_nettype wire

/* rtl/spmw_cfg_regs.sv */
`default_nettype none
module spmw_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [spmw_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [spmw_pkg::PDATA_W-1:0]   pwdata,
  output logic      [spmw_pkg::PDATA_W-1:0]   prdata,
  output logic                                pready,
  output spmw_pkg::cfg_t                      cfg
);

  logic                                wr_en;
  logic [spmw_pkg::REG_IDX_W-1:0]      reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[spmw_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cpol      <= 1'b0;
      cfg.cpha      <= 1'b0;
      cfg.lsb_first <= 1'b0;
      cfg.cs_active <= 1'b0;
      cfg.guard     <= spmw_pkg::GUARD_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        spmw_pkg::REG_CPOL:      cfg.cpol      <= pwdata[0];
        spmw_pkg::REG_CPHA:      cfg.cpha      <= pwdata[0];
        spmw_pkg::REG_LSB_FIRST: cfg.lsb_first <= pwdata[0];
        spmw_pkg::REG_CS_LEVEL:  cfg.cs_active <= pwdata[0];
        spmw_pkg::REG_GUARD:     cfg.guard     <= pwdata[spmw_pkg::GUARD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      spmw_pkg::REG_CPOL:      prdata = spmw_pkg::PDATA_W'(cfg.cpol);
      spmw_pkg::REG_CPHA:      prdata = spmw_pkg::PDATA_W'(cfg.cpha);
      spmw_pkg::REG_LSB_FIRST: prdata = spmw_pkg::PDATA_W'(cfg.lsb_first);
      spmw_pkg::REG_CS_LEVEL:  prdata = spmw_pkg::PDATA_W'(cfg.cs_active);
      spmw_pkg::REG_GUARD:     prdata = spmw_pkg::PDATA_W'(cfg.guard);
      default:                 prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/spmw_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module spmw_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              res_valid,
  input wire logic                              res_ready,
  input wire logic                              res_cs_level,
  input wire logic                              res_sclk_level,
  input wire logic                              res_dout_level,
  input wire logic                              res_ready_res,
  input wire logic                              res_rx_valid,
  input wire logic [spmw_pkg::DATA_W-1:0]       res_rx_word,
  input wire logic                              res_rejected
);

  // A stalled result holds until the transfer
  `ASSERT_NEXT(a_res_hold, clk, !rst && res_valid && !res_ready, res_valid && $stable(res_cs_level) && $stable(res_sclk_level) && $stable(res_dout_level) && $stable(res_ready_res) && $stable(res_rx_valid) && $stable(res_rx_word) && $stable(res_rejected))

  // Received word reads zero unless a read word just completed
  `ASSERT_IMPLY(a_rx_word_zero, clk, rst, res_valid && !res_rx_valid, res_rx_word == '0)

  // Reset drops the result
  `ASSERT_NEXT(a_reset_flush, clk, rst, !res_valid)

endmodule

bind spi_master_variable_word_core spmw_checker u_spmw_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_cs_level   (res.cs_level),
  .res_sclk_level (res.sclk_level),
  .res_dout_level (res.dout_level),
  .res_ready_res  (res.ready_res),
  .res_rx_valid   (res.rx_valid),
  .res_rx_word    (res.rx_word),
  .res_rejected   (res.rejected)
);
`default_nettype wire

/* bench/spi_master_variable_word_core_tb.sv */
`default_nettype none
module spi_master_variable_word_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXW = spmw_pkg::MAX_WORD_BITS_DEF;
  localparam int QUIET_LIMIT = 5000;
  localparam int RANDOM_TICKS = 1200;
  localparam int PHASES = 8;
  localparam logic [spmw_pkg::ACT_W-1:0] ACT_SPARE = 2'd3;

  typedef struct {
    logic [spmw_pkg::ACT_W-1:0]  action;
    logic [spmw_pkg::LEN_W-1:0]  word_bits;
    logic [spmw_pkg::DATA_W-1:0] tx_word;
    logic                        last_in_frame;
    logic                        din_sample;
  } tick_t;

  typedef struct {
    logic                        cs;
    logic                        sclk;
    logic                        dout;
    logic                        can_take;
    logic                        rx_valid;
    logic [spmw_pkg::DATA_W-1:0] rx_word;
    logic                        rejected;
  } pins_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [spmw_pkg::ADDR_W-1:0] paddr;
  logic [spmw_pkg::PDATA_W-1:0] pwdata, prdata;
  logic pready;

  spmw_cmd_if cmd();
  spmw_res_if res();

  spi_master_variable_word_core dut (
    .clk(clk), .rst(rst), .cmd(cmd), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // Shadow of the block: configuration and frame state.
  spmw_pkg::cfg_t   spi_cfg;
  spmw_pkg::phase_t frame_ph;
  logic [1:0]  guard_left, tick_pos;
  logic [5:0]  bit_pos, word_len;
  logic [31:0] tx_bits, rx_bits;
  logic        reading, close_after, sclk_now, dout_now;

  tick_t tick_q[$];
  pins_t pins_due[$];
  tick_t held_tick;
  int    mismatches = 0;
  int    gap_left = 0, stall_left = 0, cmd_calm = 0, res_calm = 0;
  int    quiet = 0;

  function automatic logic [1:0] guard_span(logic [1:0] g);
    if (g == 2'd0) return 2'd1;
    if (g == 2'd3) return 2'd2;
    return g;
  endfunction

  function automatic logic [5:0] clamp_len(logic [5:0] n);
    if (n == 6'd0) return 6'd1;
    if (n > MAXW) return 6'(MAXW);
    return n;
  endfunction

  function automatic void clear_shadow();
    spi_cfg = '{cpol: 1'b0, cpha: 1'b0, lsb_first: 1'b0, cs_active: 1'b0,
                guard: spmw_pkg::GUARD_RESET};
    frame_ph = spmw_pkg::PH_IDLE;
    guard_left = '0; tick_pos = '0; bit_pos = '0; word_len = '0;
    tx_bits = '0; rx_bits = '0;
    reading = 1'b0; close_after = 1'b0; sclk_now = 1'b0; dout_now = 1'b0;
  endfunction

  // Pin levels and flags after one tick; advances the shadow state.
  function automatic pins_t advance_pins(tick_t t);
    pins_t p;
    logic  word_cmd, bitv, smp, fin;
    logic [5:0] pos;
    p = '{default: '0};
    smp = 1'b0;
    fin = 1'b0;
    word_cmd = (t.action == spmw_pkg::ACT_WRITE) || (t.action == spmw_pkg::ACT_READ);
    if ((frame_ph == spmw_pkg::PH_IDLE || frame_ph == spmw_pkg::PH_OPEN) && word_cmd) begin
      word_len = clamp_len(t.word_bits);
      bit_pos = '0;
      tick_pos = '0;
      tx_bits = t.tx_word;
      rx_bits = '0;
      reading = (t.action == spmw_pkg::ACT_READ);
      close_after = t.last_in_frame;
      if (frame_ph == spmw_pkg::PH_IDLE) begin
        guard_left = guard_span(spi_cfg.guard) - 2'd1;
        frame_ph = spmw_pkg::PH_GUARD;
      end else begin
        frame_ph = spmw_pkg::PH_SHIFT;
      end
    end else if (frame_ph == spmw_pkg::PH_GUARD) begin
      p.rejected = word_cmd;
      if (guard_left == 2'd0)
        frame_ph = (bit_pos < word_len) ? spmw_pkg::PH_SHIFT : spmw_pkg::PH_IDLE;
      else guard_left = guard_left - 2'd1;
    end else if (frame_ph == spmw_pkg::PH_SHIFT) begin
      pos = spi_cfg.lsb_first ? bit_pos : 6'(word_len - 6'd1 - bit_pos);
      bitv = tx_bits[pos[4:0]];
      p.rejected = word_cmd;
      if (!spi_cfg.cpha) begin
        case (tick_pos)
          2'd0: begin
            if (!reading) dout_now = bitv;
            smp = 1'b1;
          end
          2'd1: sclk_now = ~spi_cfg.cpol;
          2'd2: ;
          default: begin
            sclk_now = spi_cfg.cpol;
            fin = 1'b1;
          end
        endcase
      end else begin
        case (tick_pos)
          2'd0: begin
            sclk_now = ~spi_cfg.cpol;
            if (!reading) dout_now = bitv;
          end
          2'd1: ;
          2'd2: sclk_now = spi_cfg.cpol;
          default: begin
            smp = 1'b1;
            fin = 1'b1;
          end
        endcase
      end
      if (smp && reading) rx_bits[pos[4:0]] = rx_bits[pos[4:0]] | t.din_sample;
      tick_pos = tick_pos + 2'd1;
      if (fin) begin
        bit_pos = bit_pos + 6'd1;
        if (bit_pos >= word_len) begin
          if (reading) begin
            p.rx_valid = 1'b1;
            p.rx_word = rx_bits;
          end
          if (close_after) begin
            frame_ph = spmw_pkg::PH_GUARD;
            guard_left = guard_span(spi_cfg.guard);
          end else begin
            frame_ph = spmw_pkg::PH_OPEN;
          end
        end
      end
    end
    if (frame_ph != spmw_pkg::PH_SHIFT) sclk_now = spi_cfg.cpol;
    p.cs = (frame_ph != spmw_pkg::PH_IDLE) ? spi_cfg.cs_active : ~spi_cfg.cs_active;
    p.sclk = sclk_now;
    p.dout = dout_now;
    p.can_take = (frame_ph == spmw_pkg::PH_IDLE || frame_ph == spmw_pkg::PH_OPEN);
    return p;
  endfunction

  // Mostly short gaps, a few long ones, and calm stretches with none.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm = $urandom_range(20, 120);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic void push_tick(logic [spmw_pkg::ACT_W-1:0] a,
                                    logic [spmw_pkg::LEN_W-1:0] n,
                                    logic [spmw_pkg::DATA_W-1:0] tx, logic last, logic din);
    tick_t t;
    t = '{action: a, word_bits: n, tx_word: tx, last_in_frame: last, din_sample: din};
    tick_q.push_back(t);
  endfunction

  function automatic logic [spmw_pkg::DATA_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  function automatic logic [spmw_pkg::LEN_W-1:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return spmw_pkg::LEN_W'($urandom_range(1, 3));
    if (r < 80) return spmw_pkg::LEN_W'($urandom_range(4, 10));
    if (r < 92) return spmw_pkg::LEN_W'($urandom_range(11, 32));
    if (r < 96) return spmw_pkg::LEN_W'($urandom_range(33, 63));
    return 6'd0;
  endfunction

  // Plain tick most of the time; now and then a stray word command.
  function automatic void push_filler();
    int r;
    logic [spmw_pkg::ACT_W-1:0] a;
    r = $urandom_range(0, 99);
    if (r < 8) a = $urandom_range(0, 1) ? spmw_pkg::ACT_WRITE : spmw_pkg::ACT_READ;
    else if (r < 18) a = ACT_SPARE;
    else a = spmw_pkg::ACT_TICK;
    push_tick(a, spmw_pkg::LEN_W'($urandom_range(0, 63)), $urandom,
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  // Well-formed frames of one to three words, padded to fit, sometimes cut short.
  task automatic queue_frames(input int budget);
    int pushed, words, pad, g, n;
    logic [spmw_pkg::ACT_W-1:0] a;
    logic [spmw_pkg::LEN_W-1:0] len;
    pushed = 0;
    while (pushed < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 4);
        repeat (n) push_filler();
        pushed += n;
      end
      words = $urandom_range(1, 3);
      g = int'(guard_span(spi_cfg.guard));
      for (int w = 0; w < words; w++) begin
        a = $urandom_range(0, 1) ? spmw_pkg::ACT_WRITE : spmw_pkg::ACT_READ;
        len = pick_len();
        push_tick(a, len, pick_word(), w == words - 1, 1'($urandom_range(0, 1)));
        pad = 4 * int'(clamp_len(len)) + (w == 0 ? g : 0) + (w == words - 1 ? g + 1 : 0);
        if ($urandom_range(0, 9) == 0) pad = $urandom_range(0, pad);
        repeat (pad) push_filler();
        pushed += pad + 1;
      end
    end
  endtask

  task automatic write_reg(input logic [spmw_pkg::REG_IDX_W-1:0] idx,
                           input logic [spmw_pkg::PDATA_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      spmw_pkg::REG_CPOL:      spi_cfg.cpol = val[0];
      spmw_pkg::REG_CPHA:      spi_cfg.cpha = val[0];
      spmw_pkg::REG_LSB_FIRST: spi_cfg.lsb_first = val[0];
      spmw_pkg::REG_CS_LEVEL:  spi_cfg.cs_active = val[0];
      spmw_pkg::REG_GUARD:     spi_cfg.guard = val[1:0];
      default: ;
    endcase
  endtask

  // Upper data bits are random and must be ignored.
  task automatic program_cfg(input logic cpol, input logic cpha, input logic lsb,
                             input logic csl, input logic [1:0] g);
    write_reg(spmw_pkg::REG_CPOL, ($urandom & ~32'h1) | 32'(cpol));
    write_reg(spmw_pkg::REG_CPHA, ($urandom & ~32'h1) | 32'(cpha));
    write_reg(spmw_pkg::REG_LSB_FIRST, ($urandom & ~32'h1) | 32'(lsb));
    write_reg(spmw_pkg::REG_CS_LEVEL, ($urandom & ~32'h1) | 32'(csl));
    write_reg(spmw_pkg::REG_GUARD, ($urandom & ~32'h3) | 32'(g));
  endtask

  task automatic drain();
    while (tick_q.size() != 0 || cmd.valid || pins_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Driver: one tick per transfer, gaps drawn after each transfer.
  always @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
      cmd.action <= spmw_pkg::ACT_TICK;
      cmd.word_bits <= '0;
      cmd.tx_word <= '0;
      cmd.last_in_frame <= 1'b0;
      cmd.din_sample <= 1'b0;
      gap_left = 0;
    end else if (!cmd.valid || cmd.ready) begin
      if (cmd.valid) begin
        pins_due.push_back(advance_pins(held_tick));
        gap_left = pick_gap(cmd_calm);
      end
      if (gap_left == 0 && tick_q.size() != 0) begin
        held_tick = tick_q.pop_front();
        cmd.valid <= 1'b1;
        cmd.action <= held_tick.action;
        cmd.word_bits <= held_tick.word_bits;
        cmd.tx_word <= held_tick.tx_word;
        cmd.last_in_frame <= held_tick.last_in_frame;
        cmd.din_sample <= held_tick.din_sample;
      end else begin
        if (gap_left > 0) gap_left--;
        cmd.valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    pins_t want;
    if (rst) begin
      res.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (pins_due.size() == 0) begin
          note_mismatch("result with nothing expected", res.rx_word, '0);
        end else begin
          want = pins_due.pop_front();
          if (res.cs_level !== want.cs)
            note_mismatch("cs_level", 32'(res.cs_level), 32'(want.cs));
          if (res.sclk_level !== want.sclk)
            note_mismatch("sclk_level", 32'(res.sclk_level), 32'(want.sclk));
          if (res.dout_level !== want.dout)
            note_mismatch("dout_level", 32'(res.dout_level), 32'(want.dout));
          if (res.ready_res !== want.can_take)
            note_mismatch("ready_res", 32'(res.ready_res), 32'(want.can_take));
          if (res.rx_valid !== want.rx_valid)
            note_mismatch("rx_valid", 32'(res.rx_valid), 32'(want.rx_valid));
          if (res.rx_word !== want.rx_word) note_mismatch("rx_word", res.rx_word, want.rx_word);
          if (res.rejected !== want.rejected)
            note_mismatch("rejected", 32'(res.rejected), 32'(want.rejected));
        end
        stall_left = pick_gap(res_calm);
      end
      res.ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("spi_master_variable_word_core_tb NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    clear_shadow();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Zero length word opening a frame, busy commands, spare action.
    push_tick(spmw_pkg::ACT_WRITE, 6'd0, '1, 1'b0, 1'b1);
    push_tick(spmw_pkg::ACT_WRITE, 6'd5, '0, 1'b1, 1'b0);
    push_tick(ACT_SPARE, 6'd63, '1, 1'b1, 1'b1);
    push_tick(spmw_pkg::ACT_READ, 6'd1, '0, 1'b0, 1'b0);
    repeat (2) push_tick(spmw_pkg::ACT_TICK, 6'd0, '0, 1'b0, 1'b1);
    // Read in the open frame, then close it.
    push_tick(spmw_pkg::ACT_READ, 6'd2, '1, 1'b1, 1'b0);
    repeat (10) push_tick(spmw_pkg::ACT_TICK, 6'd63, '1, 1'b1, 1'($urandom_range(0, 1)));
    push_tick(spmw_pkg::ACT_WRITE, 6'd1, '0, 1'b1, 1'b1);
    repeat (7) push_tick(spmw_pkg::ACT_TICK, 6'd0, '0, 1'b0, 1'b0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: program_cfg(1'b0, 1'b0, 1'b0, 1'b0, 2'd0);
        1: program_cfg(1'b1, 1'b1, 1'b1, 1'b1, 2'd3);
        2: program_cfg(1'b1, 1'b0, 1'b1, 1'b0, 2'd2);
        3: program_cfg(1'b0, 1'b1, 1'b0, 1'b1, 2'd1);
        default: program_cfg(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             2'($urandom_range(0, 3)));
      endcase
      @(negedge clk);
      queue_frames(RANDOM_TICKS / PHASES);
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && pins_due.size() == 0) begin
      $display("spi_master_variable_word_core_tb OK");
    end else begin
      $display("spi_master_variable_word_core_tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
